FILE: hw/rtl/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types and codes for the framed response receiver: item payloads,
// configuration fields, function codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_BADHDR  = 3'd2;
  localparam logic [2:0] ST_BADSUM  = 3'd3;
  localparam logic [2:0] ST_BADEND  = 3'd4;
  localparam logic [2:0] ST_NOACK   = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;
  localparam logic [2:0] ST_IDLE    = 3'd7;

  localparam logic [1:0] REG_ECHO_LENGTH   = 2'd0;
  localparam logic [1:0] REG_TWO_MESSAGES  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [8:0]  ECHO_LENGTH_RESET   = 9'd4;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [8:0] MAX_FRAME_LENGTH = 9'd256;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       message_index;
  } out_item_t;

  typedef struct packed {
    logic [8:0]  echo_length;
    logic        two_messages;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

FILE: hw/rtl/frr_cfg_regs.sv
// ----------------------------------------------------------------------------
// frr_cfg_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module frr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [frr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [frr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output frr_pkg::cfg_t                 cfg
);
  import frr_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;
  cfg_t       regs;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.echo_length   <= ECHO_LENGTH_RESET;
      regs.two_messages  <= 1'b0;
      regs.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_ECHO_LENGTH:   regs.echo_length   <= pwdata[8:0];
        REG_TWO_MESSAGES:  regs.two_messages  <= pwdata[0];
        REG_TIMEOUT_TICKS: regs.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ECHO_LENGTH:   prdata = {23'd0, regs.echo_length};
      REG_TWO_MESSAGES:  prdata = {31'd0, regs.two_messages};
      REG_TIMEOUT_TICKS: prdata = {16'd0, regs.timeout_ticks};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/frr_parser.sv
// ----------------------------------------------------------------------------
// frr_parser
// Frame parser state and its single-step update: echo skip, header, length,
// data, checksum and end byte, acknowledge check and tick timeout.
// ----------------------------------------------------------------------------
module frr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  frr_pkg::in_item_t   item,
  input  frr_pkg::cfg_t       cfg,
  output frr_pkg::out_item_t  res
);
  import frr_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_ECHO   = 7'b0000010,
    PH_HEADER = 7'b0000100,
    PH_LEN    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CKSUM  = 7'b0100000,
    PH_END    = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [8:0]  frame_length, frame_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  first_data, first_data_next;
  logic        second_pending, second_pending_next;
  logic [15:0] tick_count, tick_count_next;
  logic        in_second, in_second_next;

  logic [8:0]  count_inc;
  logic [15:0] tick_inc;
  logic [7:0]  cksum_expect;
  logic [7:0]  b;

  assign b            = item.rx_byte;
  assign count_inc    = byte_count + 9'd1;
  assign tick_inc     = tick_count + 16'd1;
  assign cksum_expect = 8'd0 - running_sum;

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    frame_length_next   = frame_length;
    running_sum_next    = running_sum;
    first_data_next     = first_data;
    second_pending_next = second_pending;
    tick_count_next     = tick_count;
    in_second_next      = in_second;
    res                 = '0;
    res.status          = ST_RUNNING;

    if (item.func == FUNC_START) begin
      phase_next          = (cfg.echo_length == 9'd0) ? PH_HEADER : PH_ECHO;
      byte_count_next     = '0;
      frame_length_next   = '0;
      running_sum_next    = '0;
      first_data_next     = '0;
      second_pending_next = cfg.two_messages;
      tick_count_next     = '0;
      in_second_next      = 1'b0;
    end else if (phase == PH_IDLE) begin
      res.status = ST_IDLE;
    end else if (item.func == FUNC_TICK) begin
      tick_count_next = tick_inc;
      if (tick_inc >= cfg.timeout_ticks) begin
        res.status = ST_TIMEOUT;
        phase_next = PH_IDLE;
      end
    end else if (item.func == FUNC_BYTE) begin
      case (phase)
        PH_ECHO: begin
          if (count_inc == cfg.echo_length) begin
            byte_count_next = '0;
            phase_next      = PH_HEADER;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_HEADER: begin
          if (b == BYTE_STX) begin
            phase_next = PH_LEN;
          end else begin
            res.status = ST_BADHDR;
            phase_next = PH_IDLE;
          end
        end
        PH_LEN: begin
          frame_length_next = (b == 8'd0) ? MAX_FRAME_LENGTH : {1'b0, b};
          running_sum_next  = b;
          byte_count_next   = '0;
          phase_next        = PH_DATA;
        end
        PH_DATA: begin
          res.data_valid    = 1'b1;
          res.data_byte     = b;
          res.data_index    = byte_count[7:0];
          res.message_index = in_second;
          if (byte_count == 9'd0) begin
            first_data_next = b;
          end
          running_sum_next = running_sum + b;
          if (count_inc >= frame_length) begin
            byte_count_next = '0;
            phase_next      = PH_CKSUM;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_CKSUM: begin
          if (b == cksum_expect) begin
            phase_next = PH_END;
          end else begin
            res.status = ST_BADSUM;
            phase_next = PH_IDLE;
          end
        end
        PH_END: begin
          if (b != BYTE_ETX) begin
            res.status = ST_BADEND;
            phase_next = PH_IDLE;
          end else if (second_pending) begin
            if (first_data != BYTE_ACK) begin
              res.status = ST_NOACK;
              phase_next = PH_IDLE;
            end else begin
              second_pending_next = 1'b0;
              in_second_next      = 1'b1;
              phase_next          = PH_HEADER;
            end
          end else begin
            res.status = ST_DONE;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          res.status = ST_IDLE;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_count     <= '0;
      frame_length   <= '0;
      running_sum    <= '0;
      first_data     <= '0;
      second_pending <= 1'b0;
      tick_count     <= '0;
      in_second      <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      frame_length   <= frame_length_next;
      running_sum    <= running_sum_next;
      first_data     <= first_data_next;
      second_pending <= second_pending_next;
      tick_count     <= tick_count_next;
      in_second      <= in_second_next;
    end
  end

  // A start item always leaves the parser armed.
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == FUNC_START |=> phase == PH_ECHO || phase == PH_HEADER)
    else $error("start item did not arm the parser");

  // Any final status returns the parser to idle.
  a_final_idles: assert property (@(posedge clk) disable iff (rst)
    fire && res.status != ST_RUNNING && res.status != ST_IDLE |=> phase == PH_IDLE)
    else $error("parser still active after a final status");

  // The data byte counter never reaches the frame length while in data.
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> byte_count < frame_length && frame_length != 9'd0)
    else $error("data byte counter out of range");

  // Items other than start leave an idle parser untouched.
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_IDLE && item.func != FUNC_START
    |=> phase == PH_IDLE && $stable(tick_count))
    else $error("idle parser changed state");

endmodule

FILE: hw/rtl/framed_response_receiver_core.sv
// ----------------------------------------------------------------------------
// framed_response_receiver_core
// Receiver for framed replies on a half-duplex serial line: skips the echo,
// checks header, length, checksum and end byte, and streams the data bytes.
//
//   Channel   Direction  Handshake                       Payload
//   item      in         item_valid / item_ready         in_item_t
//   result    out        result_valid / result_ready     out_item_t
//   config    in         APB psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One item per cycle is sustained while result_ready stays high; each item
// passes through the input register and then the result register.
// The per-item update is a single compare and add step on the parser state.
// Reset is synchronous; it clears both stages and the parser state.
// A stalled result holds the input register; item_ready drops only when both
// stages are full and result_ready is low.
// ----------------------------------------------------------------------------
module framed_response_receiver_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  frr_pkg::in_item_t             item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output frr_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [frr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [frr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  import frr_pkg::*;

  cfg_t      cfg;
  logic      stage_valid;
  in_item_t  stage_item;
  out_item_t step_result;
  logic      advance;
  logic      fire;

  assign advance    = !result_valid || result_ready;
  assign fire       = stage_valid && advance;
  assign item_ready = !stage_valid || advance;

  frr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (stage_item),
    .cfg  (cfg),
    .res  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        stage_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
    if (fire) begin
      result <= step_result;
    end
  end

endmodule
